/* sv/mwpo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared constants, types and the quarter-wave sine table generator for the
// multiwave phase oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 8;
    localparam int SINE_TAB_N      = 1 << SINE_TABLE_BITS;
    localparam int SAMPLE_W        = 16;
    localparam int INC_W           = 32;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 4;
    localparam int REG_IDX_W       = 2;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor series denominators (2k)(2k+1) for k = 1..6.
    localparam logic [63:0] TAYLOR_DIV [6] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WAVE_MODE = 2'd0,
        REG_BASE_INC  = 2'd1,
        REG_GLIDE     = 2'd2,
        REG_GOAL_INC  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_mode_t;

    typedef struct packed {
        wave_mode_t                wave_mode;
        logic [INC_W-1:0]          base_increment;
        logic signed [INC_W-1:0]   glide_step;
        logic [INC_W-1:0]          goal_increment;
    } cfg_t;

    typedef struct packed {
        logic             wr;         // any register write this cycle
        logic             base_load;  // base increment written this cycle
        logic [INC_W-1:0] load_value; // value loaded into the live increment
    } cfg_evt_t;

    // One table entry: round(32767 * sin(pi/2 * i / N)) from a Q30 Taylor
    // series up to the x^13 term. Used only with constant arguments.
    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] mag;
        logic [63:0] r;
        longint      sum;
        x   = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
        mag = x;
        sum = longint'(x);
        for (int k = 0; k < 6; k++) begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = mag / TAYLOR_DIV[k];
            if ((k % 2) == 0) begin
                sum = sum - longint'(mag);
            end
            else begin
                sum = sum + longint'(mag);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

/* sv/mwpo_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_ifs
// Valid/ready channel interfaces for the tick requests and the samples.
// ----------------------------------------------------------------------------
interface mwpo_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface mwpo_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* sv/mwpo_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_cfg_regs
// APB register file: wave mode, base increment, glide step, goal increment.
// ----------------------------------------------------------------------------
module mwpo_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mwpo_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mwpo_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mwpo_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output mwpo_pkg::cfg_t                         cfg,
    output mwpo_pkg::cfg_evt_t                     evt
);
    import mwpo_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_WAVE_MODE: cfg_next.wave_mode      = wave_mode_t'(pwdata[1:0]);
                REG_BASE_INC:  cfg_next.base_increment = pwdata[INC_W-1:0];
                REG_GLIDE:     cfg_next.glide_step     = $signed(pwdata[INC_W-1:0]);
                REG_GOAL_INC:  cfg_next.goal_increment = pwdata[INC_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_WAVE_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, cfg_reg.wave_mode};
            REG_BASE_INC:  prdata = cfg_reg.base_increment;
            REG_GLIDE:     prdata = cfg_reg.glide_step;
            REG_GOAL_INC:  prdata = cfg_reg.goal_increment;
            default:       prdata = '0;
        endcase
    end

    assign cfg            = cfg_reg;
    assign evt.wr         = wr_en;
    assign evt.base_load  = wr_en && (idx == REG_BASE_INC);
    assign evt.load_value = pwdata[INC_W-1:0];

endmodule
`default_nettype wire

/* sv/mwpo_sine_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_sine_rom
// Constant quarter-wave sine table with N+1 entries, read combinationally.
// ----------------------------------------------------------------------------
module mwpo_sine_rom (
    input  wire logic [mwpo_pkg::SINE_TABLE_BITS:0] addr,
    output logic      [15:0]                        data
);
    import mwpo_pkg::*;

    logic [15:0] rom [0:SINE_TAB_N];

    for (genvar i = 0; i <= SINE_TAB_N; i++)
    begin : g_rom
        assign rom[i] = sine_entry(i);
    end

    // The address never exceeds N: the mirrored index is N minus a table index.
    assign data = rom[addr];

endmodule
`default_nettype wire

/* sv/mwpo_wave_gen.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mwpo_wave_gen
// Maps the phase accumulator to a Q1.15 sample for the selected wave shape.
// ----------------------------------------------------------------------------
module mwpo_wave_gen (
    input  wire logic [mwpo_pkg::PHASE_BITS-1:0]   phase,
    input  wire mwpo_pkg::wave_mode_t              wave_mode,
    output logic signed [mwpo_pkg::SAMPLE_W-1:0]   sample
);
    import mwpo_pkg::*;

    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS:0]   rom_addr;
    logic [15:0]                rom_data;
    logic [15:0]                u;
    logic [15:0]                sine_val;
    logic [15:0]                saw_val;
    logic [15:0]                square_val;
    logic [15:0]                tri_val;
    logic [16:0]                saw_diff;
    logic [15:0]                tri_dist;
    logic                       at_half;

    assign u    = phase[PHASE_BITS-1 -: 16];
    assign quad = phase[PHASE_BITS-1 -: 2];
    assign idx  = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];

    // Second and fourth quadrants run the table backwards.
    assign rom_addr = quad[0] ? ((SINE_TABLE_BITS+1)'(SINE_TAB_N) - {1'b0, idx})
                              : {1'b0, idx};

    mwpo_sine_rom u_rom (
        .addr (rom_addr),
        .data (rom_data)
    );

    assign sine_val = quad[1] ? (16'd0 - rom_data) : rom_data;

    // Falling saw 32768 - u; only u == 0 reaches +1.0 and saturates.
    assign saw_diff = 17'h08000 - {1'b0, u};
    assign saw_val  = (u == 16'd0) ? 16'h7FFF : saw_diff[15:0];

    // Square is high up to and including the exact half-cycle point.
    assign at_half    = (phase == (PHASE_BITS'(1) << (PHASE_BITS-1)));
    assign square_val = (!phase[PHASE_BITS-1] || at_half) ? 16'h7FFF : 16'h8000;

    // Triangle 2*|u - 32768| - 32768; the distance is 32768 only at u == 0.
    assign tri_dist = u[15] ? {1'b0, u[14:0]} : (16'h8000 - u);
    assign tri_val  = (u == 16'd0) ? 16'h7FFF : ({tri_dist[14:0], 1'b0} ^ 16'h8000);

    always_comb
    begin
        case (wave_mode)
            WAVE_SINE:     sample = $signed(sine_val);
            WAVE_SAW:      sample = $signed(saw_val);
            WAVE_SQUARE:   sample = $signed(square_val);
            WAVE_TRIANGLE: sample = $signed(tri_val);
            default:       sample = $signed(sine_val);
        endcase
    end

endmodule
`default_nettype wire

/* sv/multiwave_phase_oscillator_glide.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multiwave_phase_oscillator_glide
// Direct digital synthesis oscillator with sine, saw, square and triangle
// shapes and a linear increment glide toward a goal.
// ----------------------------------------------------------------------------
// Usage:
//   Software programs the wave mode, base increment, glide step and goal
//   increment over the APB port while the block is idle. Writing the base
//   increment also reloads the live increment.
//   Each transaction on tick_ch with tick high produces exactly one sample
//   transaction on sample_ch; a transaction with tick low is consumed and
//   changes nothing. The sample reflects the phase before the tick, after
//   which the increment glides one step and the phase advances by it.
//   The sample is registered and valid in the cycle after the tick is
//   accepted. Throughput is one tick per cycle while sample_ch.ready stays
//   high, set by the single phase adder and the one-deep output register.
//   When the sample receiver stalls, the output register holds its sample
//   and tick_ch.ready drops until the sample is taken; a new tick is taken
//   in the same cycle the waiting sample leaves.
//   Reset zeroes the phase, the live increment, the valid flag and the config
//   registers, not the sample register; the constant sine table needs no reset.
// ----------------------------------------------------------------------------
module multiwave_phase_oscillator_glide (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mwpo_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mwpo_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mwpo_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    mwpo_tick_if.sink                              tick_ch,
    mwpo_sample_if.source                          sample_ch
);
    import mwpo_pkg::*;

    cfg_t                     cfg;
    cfg_evt_t                 evt;

    logic [PHASE_BITS-1:0]    phase_reg;
    logic [PHASE_BITS-1:0]    phase_next;
    logic [INC_W-1:0]         inc_reg;
    logic [INC_W-1:0]         inc_next;
    logic [INC_W-1:0]         glide_inc;
    logic signed [INC_W+1:0]  glide_sum;
    logic signed [INC_W+1:0]  goal_ext;
    logic                     glide_up;
    logic                     glide_on;

    logic signed [SAMPLE_W-1:0] wave_sample;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic                     in_fire;
    logic                     step_fire;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    mwpo_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .evt     (evt)
    );

    // ------------------------------------------------------------------
    // Handshake. The input is open whenever the output register is empty
    // or is being emptied in this cycle.
    // ------------------------------------------------------------------
    assign tick_ch.ready = !out_valid_reg || sample_ch.ready;
    assign in_fire       = tick_ch.valid && tick_ch.ready;
    assign step_fire     = in_fire && tick_ch.tick;

    // ------------------------------------------------------------------
    // Glide: add the signed step in a width that cannot overflow, then
    // clamp at the goal in the direction of travel. A live increment that
    // is already past the goal snaps to it on the first step.
    // ------------------------------------------------------------------
    assign glide_on  = (cfg.glide_step != '0);
    assign glide_up  = !cfg.glide_step[INC_W-1];
    assign glide_sum = $signed({2'b00, inc_reg})
                     + $signed({{2{cfg.glide_step[INC_W-1]}}, cfg.glide_step});
    assign goal_ext  = $signed({2'b00, cfg.goal_increment});

    always_comb
    begin
        glide_inc = glide_sum[INC_W-1:0];
        if (glide_up && (glide_sum > goal_ext))
        begin
            glide_inc = cfg.goal_increment;
        end
        else if (!glide_up && (glide_sum < goal_ext))
        begin
            glide_inc = cfg.goal_increment;
        end
    end

    assign inc_next   = glide_on ? glide_inc : inc_reg;
    assign phase_next = phase_reg + PHASE_BITS'(inc_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            inc_reg   <= '0;
        end
        else
        begin
            if (evt.base_load)
            begin
                inc_reg <= evt.load_value;
            end
            else if (step_fire)
            begin
                inc_reg <= inc_next;
            end
            if (step_fire)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Wave shaping from the current phase, captured in the output register.
    // ------------------------------------------------------------------
    mwpo_wave_gen u_wave (
        .phase     (phase_reg),
        .wave_mode (cfg.wave_mode),
        .sample    (wave_sample)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            sample_reg <= wave_sample;
        end
    end

    assign sample_ch.valid  = out_valid_reg;
    assign sample_ch.sample = sample_reg;

`ifndef ASSERT_OFF
    // A tick always yields a sample in the next cycle.
    a_tick_gives_sample: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg)
        else $error("tick accepted but no sample presented");

    // The phase moves only on an accepted tick.
    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(phase_reg))
        else $error("phase changed without a tick");

    // An upward glide that starts at or below the goal never overshoots it.
    a_glide_no_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && !evt.wr && glide_on && glide_up
            && (inc_reg <= cfg.goal_increment))
        |=> (inc_reg <= $past(cfg.goal_increment)))
        else $error("glide overshot the goal increment");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> tick_ch.ready)
        else $error("input stalled with empty output register");
`endif

endmodule
`default_nettype wire
